### sv/rrbb_pkg.sv
// Shared types, constants and ring arithmetic for the receive ring byte buffer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rrbb_pkg;

   // Ring depth in bytes, and the widths that follow from it
   localparam int DEPTH = 64;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Fixed field widths of the request and response beats
   localparam int BYTE_W  = 8;
   localparam int OP_W    = 2;
   localparam int DROP_W  = 7;
   localparam int LIMIT_W = 7;
   localparam int USED_W  = 7;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   // Command queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_DROP = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // Back part sequencer
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_STREAM = 2'b10
   } back_state_type;

   // One classified command
   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   data;
      logic [DROP_W-1:0]   count;
   } cmd_type;

   // Queue occupancy seen by the front part
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Advance a ring pointer by n places, n at most DEPTH
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(p) + (CNT_W + 1)'(n);
      if (s >= (CNT_W + 1)'(DEPTH)) begin
         s = s - (CNT_W + 1)'(DEPTH);
      end
      return PTR_W'(s);
   endfunction

   // Advance a ring pointer by one place
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/rrbb_front.sv
// Front part: takes request beats, decodes the operation and hands commands to the queue.
// Depends on rrbb_pkg.
`default_nettype none

module rrbb_front (
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [rrbb_pkg::REQ_W-1:0]    req_tdata,   // op, data_byte, drop_count
   input  wire rrbb_pkg::queue_status_type    queue_status,
   output logic                               cmd_push,
   output rrbb_pkg::cmd_type                  cmd
);

   logic [rrbb_pkg::OP_W-1:0] raw_op;

   assign raw_op     = req_tdata[1:0];
   assign req_tready = !queue_status.full;
   assign cmd_push   = req_tvalid && !queue_status.full;

   // Classify the operation and unpack the payload
   always_comb begin
      case (raw_op)
         rrbb_pkg::OP_PUSH: cmd.op = rrbb_pkg::OP_PUSH;
         rrbb_pkg::OP_DROP: cmd.op = rrbb_pkg::OP_DROP;
         rrbb_pkg::OP_READ: cmd.op = rrbb_pkg::OP_READ;
         default:           cmd.op = rrbb_pkg::OP_NONE;
      endcase
      cmd.data  = req_tdata[9:2];
      cmd.count = req_tdata[16:10];
   end

endmodule

`default_nettype wire

### sv/rrbb_cmd_queue.sv
// Short command queue between the front and back parts of the ring buffer.
// Depends on rrbb_pkg.
`default_nettype none

module rrbb_cmd_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire rrbb_pkg::cmd_type             push_cmd,
   input  wire logic                          pop,
   output rrbb_pkg::cmd_type                  head_cmd,
   output logic                               head_valid,
   output rrbb_pkg::queue_status_type         status
);

   rrbb_pkg::cmd_type                 entry_ff [rrbb_pkg::QUEUE_DEPTH];
   logic [rrbb_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rrbb_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rrbb_pkg::QCNT_W-1:0]       fill_ff, fill_in;
   logic                              do_push, do_pop;

   assign status.full  = (fill_ff == rrbb_pkg::QCNT_W'(rrbb_pkg::QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign head_valid   = !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rrbb_pkg::QPTR_W'(rrbb_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + rrbb_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rrbb_pkg::QPTR_W'(rrbb_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + rrbb_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + rrbb_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - rrbb_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold entries; no reset on payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### sv/rrbb_back.sv
// Back part: owns the byte store, ring pointers and count, executes commands
// and drives the registered response beat. Depends on rrbb_pkg.
`default_nettype none

module rrbb_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [rrbb_pkg::LIMIT_W-1:0]    csr_wdata,
   input  wire rrbb_pkg::cmd_type               cmd,
   input  wire logic                            cmd_valid,
   output logic                                 cmd_pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [rrbb_pkg::RSP_W-1:0]           rsp_tdata,   // read_byte, used
   output logic [1:0]                           rsp_tuser,   // ok, has_byte
   output logic                                 rsp_tlast
);

   // Byte store, undefined until written
   logic [rrbb_pkg::BYTE_W-1:0]       mem [rrbb_pkg::DEPTH];

   rrbb_pkg::back_state_type          state_ff, state_in;
   logic [rrbb_pkg::PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [rrbb_pkg::PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [rrbb_pkg::CNT_W-1:0]        held_ff, held_in;
   logic [rrbb_pkg::LIMIT_W-1:0]      limit_ff;
   logic [rrbb_pkg::PTR_W-1:0]        iter_ff, iter_in;
   logic [rrbb_pkg::CNT_W-1:0]        left_ff, left_in;

   logic                              out_valid_ff;
   logic                              ok_ff, ok_in;
   logic                              hb_ff, hb_in;
   logic                              last_ff, last_in;
   logic [rrbb_pkg::CNT_W-1:0]        used_ff;
   logic [rrbb_pkg::BYTE_W-1:0]       byte_ff;

   logic                              load;
   logic                              emit;
   logic                              mem_we;
   logic                              rd_en;
   logic [rrbb_pkg::PTR_W-1:0]        rd_addr;

   // Output register free or draining this cycle
   assign load = !out_valid_ff || rsp_tready;

   // Sequence commands and streamed reads
   always_comb begin
      state_in  = state_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      held_in   = held_ff;
      iter_in   = iter_ff;
      left_in   = left_ff;
      emit      = 1'b0;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = iter_ff;
      ok_in     = 1'b0;
      hb_in     = 1'b0;
      last_in   = 1'b1;
      case (state_ff)
         rrbb_pkg::ST_STREAM: begin
            if (load) begin
               emit    = 1'b1;
               rd_en   = 1'b1;
               ok_in   = 1'b1;
               hb_in   = 1'b1;
               last_in = (left_ff == rrbb_pkg::CNT_W'(1));
               iter_in = rrbb_pkg::ring_next(iter_ff);
               left_in = left_ff - rrbb_pkg::CNT_W'(1);
               if (last_in) begin
                  state_in = rrbb_pkg::ST_IDLE;
               end
            end
         end
         rrbb_pkg::ST_IDLE: begin
            if (load && cmd_valid) begin
               emit    = 1'b1;
               cmd_pop = 1'b1;
               case (cmd.op)
                  rrbb_pkg::OP_PUSH: begin
                     // refuse when full
                     if (held_ff != rrbb_pkg::CNT_W'(rrbb_pkg::DEPTH)) begin
                        mem_we    = 1'b1;
                        wr_ptr_in = rrbb_pkg::ring_next(wr_ptr_ff);
                        held_in   = held_ff + rrbb_pkg::CNT_W'(1);
                        ok_in     = 1'b1;
                     end
                  end
                  rrbb_pkg::OP_DROP: begin
                     // over-long drop clears the ring
                     if (cmd.count > rrbb_pkg::DROP_W'(held_ff)) begin
                        rd_ptr_in = '0;
                        wr_ptr_in = '0;
                        held_in   = '0;
                     end else begin
                        rd_ptr_in = rrbb_pkg::ring_add(rd_ptr_ff,
                                                       rrbb_pkg::CNT_W'(cmd.count));
                        held_in   = held_ff - rrbb_pkg::CNT_W'(cmd.count);
                        ok_in     = 1'b1;
                     end
                  end
                  rrbb_pkg::OP_READ: begin
                     // empty or over the limit gives one failure beat
                     if (held_ff != '0 &&
                         rrbb_pkg::LIMIT_W'(held_ff) <= limit_ff) begin
                        ok_in   = 1'b1;
                        hb_in   = 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = rd_ptr_ff;
                        last_in = (held_ff == rrbb_pkg::CNT_W'(1));
                        iter_in = rrbb_pkg::ring_next(rd_ptr_ff);
                        left_in = held_ff - rrbb_pkg::CNT_W'(1);
                        if (!last_in) begin
                           state_in = rrbb_pkg::ST_STREAM;
                        end
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = rrbb_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrbb_pkg::ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         held_ff      <= '0;
         iter_ff      <= '0;
         left_ff      <= '0;
         limit_ff     <= rrbb_pkg::LIMIT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         held_ff   <= held_in;
         iter_ff   <= iter_in;
         left_ff   <= left_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (load) begin
            out_valid_ff <= emit;
         end
      end
   end

   // Byte store write and registered read into the response beat
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= cmd.data;
      end
      if (emit) begin
         byte_ff <= rd_en ? mem[rd_addr] : '0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (emit) begin
         ok_ff   <= ok_in;
         hb_ff   <= hb_in;
         last_ff <= last_in;
         used_ff <= held_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, rrbb_pkg::USED_W'(used_ff), byte_ff};
   assign rsp_tuser  = {hb_ff, ok_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

### sv/receive_ring_byte_buffer.sv
// Receive ring byte buffer, top level: front decode, command queue, back execution.
// A request waits in the command queue; the back part registers its result beat.
// Push, drop and failed reads give one beat each; a successful read holds the back
// part for held-count bytes, one byte per cycle from the store port unless stalled.
// Reset clears pointers, count and queue and sets read_limit to 64; the byte store
// is not cleared.
`default_nettype none

module receive_ring_byte_buffer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [rrbb_pkg::LIMIT_W-1:0]    csr_wdata,   // read_limit
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [rrbb_pkg::REQ_W-1:0]      req_tdata,   // op, data_byte, drop_count
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [rrbb_pkg::RSP_W-1:0]           rsp_tdata,   // read_byte, used
   output logic [1:0]                           rsp_tuser,   // ok, has_byte
   output logic                                 rsp_tlast
);

   rrbb_pkg::queue_status_type   queue_status;
   rrbb_pkg::cmd_type            front_cmd;
   rrbb_pkg::cmd_type            head_cmd;
   logic                         front_push;
   logic                         head_valid;
   logic                         back_pop;

   rrbb_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .queue_status (queue_status),
      .cmd_push     (front_push),
      .cmd          (front_cmd)
   );

   rrbb_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_cmd   (front_cmd),
      .pop        (back_pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .status     (queue_status)
   );

   rrbb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (head_cmd),
      .cmd_valid  (head_valid),
      .cmd_pop    (back_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Held count never exceeds the ring depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:8] <= rrbb_pkg::USED_W'(rrbb_pkg::DEPTH)))
      else $error("used count above ring depth");

   // A byte beat is always a successful one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("byte beat without ok");

   // A beat without a byte ends its command and carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tlast && rsp_tdata[7:0] == '0))
      else $error("non-byte beat not last or byte not zero");

endmodule

`default_nettype wire

### dv/receive_ring_byte_buffer_test.sv
// Self-checking testbench for receive_ring_byte_buffer: a directed opening, then random push,
// drop and read traffic under several read limits, checked beat by beat against a predictor.
// Depends on rrbb_pkg and the receive_ring_byte_buffer RTL only.
`timescale 1ns / 100ps

module receive_ring_byte_buffer_test;

   localparam int SETTLE_CYCLES = 3;
   localparam int DRAIN_CYCLES  = 8;
   localparam int IDLE_PERCENT  = 28;
   localparam int CALM_FROM     = 300;
   localparam int CALM_TO       = 700;
   localparam int PAD_W         = rrbb_pkg::REQ_W - rrbb_pkg::OP_W - rrbb_pkg::BYTE_W
                                  - rrbb_pkg::DROP_W;

   // Kinds of entries in the stimulus queue
   typedef enum {STEP_BEAT, STEP_CSR, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type                  kind;
      rrbb_pkg::op_type               op;
      logic [rrbb_pkg::BYTE_W-1:0]    data;
      logic [rrbb_pkg::DROP_W-1:0]    count;
      logic [rrbb_pkg::LIMIT_W-1:0]   value;
   } stim_step_type;

   typedef struct {
      logic                           ok;
      logic                           has_byte;
      logic [rrbb_pkg::BYTE_W-1:0]    read_byte;
      logic                           last;
      logic [rrbb_pkg::USED_W-1:0]    used;
   } rsp_beat_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [rrbb_pkg::LIMIT_W-1:0]   csr_wdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rrbb_pkg::REQ_W-1:0]     req_tdata = '0;  // op, data_byte, drop_count (from bit 0 up)
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rrbb_pkg::RSP_W-1:0]     rsp_tdata;       // read_byte, used (from bit 0 up)
   logic [1:0]                     rsp_tuser;       // ok, has_byte (from bit 0 up)
   logic                           rsp_tlast;

   stim_step_type       pending_steps[$];
   rsp_beat_type        expected_rsp_q[$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  settle_count = 0;
   int                  stim_held = 0;
   logic                calm;

   // Predicted ring state
   logic [rrbb_pkg::BYTE_W-1:0]   ring_bytes[rrbb_pkg::DEPTH];
   int                            ring_head = 0;
   int                            ring_tail = 0;
   int                            ring_held = 0;
   int                            ring_limit = int'(rrbb_pkg::LIMIT_RESET);

   receive_ring_byte_buffer DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Count cycles; no idling on either side inside the calm window
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end
   assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void expect_outcome(input logic ok, input logic has_byte,
                                          input logic [rrbb_pkg::BYTE_W-1:0] byte_val,
                                          input logic last);
      rsp_beat_type b;
      b.ok        = ok;
      b.has_byte  = has_byte;
      b.read_byte = byte_val;
      b.last      = last;
      b.used      = rrbb_pkg::USED_W'(ring_held);
      expected_rsp_q.push_back(b);
   endfunction

   // Work out the response beats of one accepted request and advance the ring
   function automatic void predict_ring_op(input logic [rrbb_pkg::REQ_W-1:0] beat);
      rrbb_pkg::op_type              op;
      logic [rrbb_pkg::BYTE_W-1:0]   data;
      int                            cnt;
      int                            p;
      op   = rrbb_pkg::op_type'(beat[rrbb_pkg::OP_W-1:0]);
      data = beat[rrbb_pkg::OP_W +: rrbb_pkg::BYTE_W];
      cnt  = int'(beat[rrbb_pkg::OP_W+rrbb_pkg::BYTE_W +: rrbb_pkg::DROP_W]);
      case (op)
         rrbb_pkg::OP_PUSH: begin
            if (ring_held >= rrbb_pkg::DEPTH) begin
               expect_outcome(1'b0, 1'b0, '0, 1'b1);
            end else begin
               ring_bytes[ring_tail] = data;
               ring_tail = (ring_tail + 1) % rrbb_pkg::DEPTH;
               ring_held++;
               expect_outcome(1'b1, 1'b0, '0, 1'b1);
            end
         end
         rrbb_pkg::OP_DROP: begin
            if (cnt > ring_held) begin
               ring_head = 0;
               ring_tail = 0;
               ring_held = 0;
               expect_outcome(1'b0, 1'b0, '0, 1'b1);
            end else begin
               ring_head = (ring_head + cnt) % rrbb_pkg::DEPTH;
               ring_held -= cnt;
               expect_outcome(1'b1, 1'b0, '0, 1'b1);
            end
         end
         rrbb_pkg::OP_READ: begin
            if (ring_held == 0 || ring_held > ring_limit) begin
               expect_outcome(1'b0, 1'b0, '0, 1'b1);
            end else begin
               p = ring_head;
               for (int i = 0; i < ring_held; i++) begin
                  expect_outcome(1'b1, 1'b1, ring_bytes[p], (i + 1 == ring_held));
                  p = (p + 1) % rrbb_pkg::DEPTH;
               end
            end
         end
         default: begin
            expect_outcome(1'b0, 1'b0, '0, 1'b1);
         end
      endcase
   endfunction

   // Compare one response beat with the oldest expectation
   task automatic check_rsp_beat();
      rsp_beat_type want;
      rsp_beat_type got;
      got.ok        = rsp_tuser[0];
      got.has_byte  = rsp_tuser[1];
      got.read_byte = rsp_tdata[rrbb_pkg::BYTE_W-1:0];
      got.last      = rsp_tlast;
      got.used      = rsp_tdata[rrbb_pkg::BYTE_W +: rrbb_pkg::USED_W];
      if (expected_rsp_q.size() == 0) begin
         report_error($sformatf("response beat with none expected (byte %0d, used %0d)",
                                got.read_byte, got.used));
      end else begin
         want = expected_rsp_q.pop_front();
         if (got.ok !== want.ok)
            report_error($sformatf("ok: expected %0d got %0b", want.ok, got.ok));
         if (got.has_byte !== want.has_byte)
            report_error($sformatf("has_byte: expected %0d got %0b",
                                   want.has_byte, got.has_byte));
         if (got.read_byte !== want.read_byte)
            report_error($sformatf("read_byte: expected %0d got %0d",
                                   want.read_byte, got.read_byte));
         if (got.last !== want.last)
            report_error($sformatf("last: expected %0d got %0b", want.last, got.last));
         if (got.used !== want.used)
            report_error($sformatf("used: expected %0d got %0d", want.used, got.used));
      end
   endtask

   // Request driver: feed beats from the stimulus queue, apply register writes when quiet
   always @(posedge clock) begin
      stim_step_type                  step;
      logic                           nxt_valid;
      logic [rrbb_pkg::REQ_W-1:0]     nxt_data;
      logic                           nxt_we;
      logic [rrbb_pkg::LIMIT_W-1:0]   nxt_wdata;
      logic                           quiet;
      if (reset) begin
         req_tvalid   <= 1'b0;
         csr_we       <= 1'b0;
         settle_count <= 0;
      end else begin
         nxt_valid = req_tvalid;
         nxt_data  = req_tdata;
         nxt_we    = 1'b0;
         nxt_wdata = csr_wdata;
         if (req_tvalid && req_tready) begin
            predict_ring_op(req_tdata);
            nxt_valid = 1'b0;
         end
         quiet = !req_tvalid && expected_rsp_q.size() == 0 && settle_count >= SETTLE_CYCLES;
         if (req_tvalid || expected_rsp_q.size() != 0)
            settle_count <= 0;
         else if (settle_count < SETTLE_CYCLES)
            settle_count <= settle_count + 1;
         if (!nxt_valid && pending_steps.size() != 0) begin
            step = pending_steps[0];
            case (step.kind)
               STEP_BEAT: begin
                  if (calm || $urandom_range(99) >= IDLE_PERCENT) begin
                     nxt_valid = 1'b1;
                     nxt_data  = {{PAD_W{1'b0}}, step.count, step.data, step.op};
                     void'(pending_steps.pop_front());
                  end
               end
               STEP_CSR: begin
                  if (quiet) begin
                     nxt_we     = 1'b1;
                     nxt_wdata  = step.value;
                     ring_limit = int'(step.value);
                     void'(pending_steps.pop_front());
                  end
               end
               default: begin
                  if (quiet)
                     void'(pending_steps.pop_front());
               end
            endcase
         end
         req_tvalid <= nxt_valid;
         req_tdata  <= nxt_data;
         csr_we     <= nxt_we;
         csr_wdata  <= nxt_wdata;
      end
   end

   // Response monitor: check each accepted beat, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_rsp_beat();
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Stimulus builders; stim_held tracks fill level to shape the sequences
   function automatic void add_beat(input rrbb_pkg::op_type op, input int data, input int cnt);
      stim_step_type s;
      s.kind  = STEP_BEAT;
      s.op    = op;
      s.data  = rrbb_pkg::BYTE_W'(data);
      s.count = rrbb_pkg::DROP_W'(cnt);
      s.value = '0;
      pending_steps.push_back(s);
      if (op == rrbb_pkg::OP_PUSH && stim_held < rrbb_pkg::DEPTH)
         stim_held++;
      else if (op == rrbb_pkg::OP_DROP)
         stim_held = (cnt > stim_held) ? 0 : stim_held - cnt;
   endfunction

   function automatic void add_control(input step_kind_type kind, input int value);
      stim_step_type s;
      s.kind  = kind;
      s.op    = rrbb_pkg::OP_NONE;
      s.data  = '0;
      s.count = '0;
      s.value = rrbb_pkg::LIMIT_W'(value);
      pending_steps.push_back(s);
   endfunction

   // Random traffic: push bursts, reads, legal drops, and some noise
   function automatic void add_random_phase(input int beats);
      int added;
      int r;
      int n;
      added = 0;
      while (added < beats) begin
         r = $urandom_range(99);
         if (r < 8) begin
            if (stim_held < rrbb_pkg::DEPTH && $urandom_range(1) == 1)
               add_beat(rrbb_pkg::OP_DROP, $urandom_range(255),
                        $urandom_range(rrbb_pkg::DEPTH, stim_held + 1));
            else
               add_beat(rrbb_pkg::OP_NONE, $urandom_range(255),
                        $urandom_range(rrbb_pkg::DEPTH));
            added++;
         end else if (r < 45) begin
            n = $urandom_range(6, 1);
            repeat (n) add_beat(rrbb_pkg::OP_PUSH, $urandom_range(255),
                                $urandom_range(rrbb_pkg::DEPTH));
            added += n;
         end else if (r < 70) begin
            add_beat(rrbb_pkg::OP_READ, $urandom_range(255), $urandom_range(rrbb_pkg::DEPTH));
            added++;
         end else begin
            n = ($urandom_range(4) == 0) ? stim_held : $urandom_range(stim_held);
            add_beat(rrbb_pkg::OP_DROP, $urandom_range(255), n);
            added++;
         end
      end
   endfunction

   initial begin
      // Directed: empty-buffer cases, field extremes, unused op, clears
      add_beat(rrbb_pkg::OP_READ, 8'h00, 0);
      add_beat(rrbb_pkg::OP_DROP, 8'h00, 0);
      add_beat(rrbb_pkg::OP_DROP, 8'hFF, 1);
      add_beat(rrbb_pkg::OP_NONE, 8'hFF, rrbb_pkg::DEPTH);
      add_beat(rrbb_pkg::OP_PUSH, 8'h00, 0);
      add_beat(rrbb_pkg::OP_PUSH, 8'hFF, rrbb_pkg::DEPTH);
      add_beat(rrbb_pkg::OP_PUSH, 8'hA5, 0);
      add_beat(rrbb_pkg::OP_PUSH, 8'h5A, 0);
      add_beat(rrbb_pkg::OP_READ, 8'h00, 0);
      add_beat(rrbb_pkg::OP_DROP, 8'h00, 0);
      add_beat(rrbb_pkg::OP_DROP, 8'h00, 1);
      add_beat(rrbb_pkg::OP_READ, 8'h00, 0);
      add_beat(rrbb_pkg::OP_NONE, 8'h00, 0);
      add_beat(rrbb_pkg::OP_DROP, 8'h00, rrbb_pkg::DEPTH);
      add_beat(rrbb_pkg::OP_READ, 8'h00, 0);
      add_beat(rrbb_pkg::OP_PUSH, 8'h3C, 0);
      add_beat(rrbb_pkg::OP_DROP, 8'h00, 1);
      add_beat(rrbb_pkg::OP_READ, 8'h00, 0);

      // Fill to full, refuse one more, read all, empty exactly, then wrap
      while (stim_held < rrbb_pkg::DEPTH) add_beat(rrbb_pkg::OP_PUSH, $urandom_range(255), 0);
      add_beat(rrbb_pkg::OP_PUSH, 8'h81, 0);
      add_beat(rrbb_pkg::OP_READ, 0, 0);
      add_beat(rrbb_pkg::OP_DROP, 0, rrbb_pkg::DEPTH);
      add_beat(rrbb_pkg::OP_PUSH, $urandom_range(255), 0);
      add_beat(rrbb_pkg::OP_READ, 0, 0);

      // Random phases under different read limits
      add_control(STEP_CSR, 0);
      add_random_phase(18);
      add_control(STEP_CSR, 1);
      add_random_phase(18);
      add_control(STEP_CSR, 127);
      add_random_phase(22);
      add_control(STEP_DRAIN, 0);
      add_control(STEP_CSR, 5);
      add_random_phase(11);
      add_control(STEP_DRAIN, 0);
      add_random_phase(11);
      add_control(STEP_CSR, 63);
      add_random_phase(18);
      add_control(STEP_CSR, 64);
      add_random_phase(20);

      // Wait for all beats to be taken and answered, then let the pipe settle
      do @(posedge clock);
      while (reset || pending_steps.size() != 0 || req_tvalid || expected_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_error($sformatf("%0d response beats never arrived", expected_rsp_q.size()));
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
